>>> rtl/slope_pattern_pitch_detector_defines.svh
// Assertion macros for the slope pattern pitch detector.
`ifndef SLOPE_PATTERN_PITCH_DETECTOR_DEFINES_SVH
`define SLOPE_PATTERN_PITCH_DETECTOR_DEFINES_SVH
`ifndef ASSERT_OFF
`define SPD_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
`define SPD_ASSERT_RST(label, clk, prop) \
  label: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define SPD_ASSERT(label, clk, rst_n, prop)
`define SPD_ASSERT_RST(label, clk, prop)
`endif
`endif

>>> rtl/spd_pkg.sv
// ----------------------------------------------------------------------------
// spd_pkg
// Shared constants and types of the slope pattern pitch detector.
// ----------------------------------------------------------------------------
package spd_pkg;
  localparam int unsigned EventSlots = 16;
  localparam int unsigned IdxW = $clog2(EventSlots);
  localparam int unsigned CntW = $clog2(EventSlots + 1);
  localparam int unsigned QDepth = 2;

  localparam logic [2:0] CfgEqu = 3'd0;
  localparam logic [2:0] CfgSlt = 3'd1;
  localparam logic [2:0] CfgTmt = 3'd2;
  localparam logic [2:0] CfgAmp = 3'd3;
  localparam logic [2:0] CfgWin = 3'd4;
  localparam logic [2:0] CfgRate = 3'd5;
  localparam logic [2:0] CfgMin = 3'd6;
  localparam logic [2:0] CfgMax = 3'd7;

  localparam logic [1:0] EdgeNone = 2'd0;
  localparam logic [1:0] EdgeRise = 2'd1;
  localparam logic [1:0] EdgeFall = 2'd2;

  localparam logic [2:0] StNone = 3'd0;
  localparam logic [2:0] StSteep = 3'd1;
  localparam logic [2:0] StInit = 3'd2;
  localparam logic [2:0] StFound = 3'd3;
  localparam logic [2:0] StMiss = 3'd4;

  typedef struct packed {
    logic [7:0]  equ;
    logic [7:0]  slope_tol;
    logic [15:0] timer_tol;
    logic [7:0]  amp_thr;
    logic [15:0] window;
    logic [16:0] rate;
    logic [7:0]  adc_min;
    logic [7:0]  adc_max;
  } cfg_t;

  // Classified item passed from front to back.
  typedef struct packed {
    logic [1:0]  edge_kind;
    logic [7:0]  slope;
    logic        level_above;
    logic        clipping;
  } item_t;

  function automatic logic [7:0] absdiff8(logic [7:0] a, logic [7:0] b);
    return (a >= b) ? a - b : b - a;
  endfunction
endpackage

>>> rtl/spd_front.sv
// ----------------------------------------------------------------------------
// spd_front
// Shifts samples, runs the amplitude window and classifies crossings.
// ----------------------------------------------------------------------------
module spd_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  spd_pkg::cfg_t  cfg_i,
  input  logic           valid_i,
  output logic           ready_o,
  input  logic [7:0]     sample_i,
  output logic           push_o,
  output spd_pkg::item_t item_o,
  input  logic           full_i
);
  import spd_pkg::*;

  logic [7:0]  cur_q, prev_d;
  logic [15:0] win_q, win_d;
  logic [7:0]  run_q, run_d, held_q, held_d, amp, peak;
  logic [16:0] win_inc;
  logic        acc;

  assign ready_o = !full_i;
  assign acc     = valid_i && ready_o;
  assign push_o  = acc;
  assign prev_d  = cur_q;

  always_comb begin
    amp     = absdiff8(cfg_i.equ, sample_i);
    peak    = (amp > run_q) ? amp : run_q;
    win_inc = {1'b0, win_q} + 17'd1;
    win_d   = win_inc[15:0];
    run_d   = peak;
    held_d  = held_q;
    if (win_inc >= {1'b0, cfg_i.window}) begin
      held_d = peak;
      win_d  = '0;
      run_d  = '0;
    end
    item_o.slope       = sample_i - prev_d;
    item_o.level_above = held_d >= cfg_i.amp_thr;
    item_o.clipping    = (sample_i == cfg_i.adc_min) || (sample_i == cfg_i.adc_max);
    if (prev_d < cfg_i.equ && sample_i >= cfg_i.equ) begin
      item_o.edge_kind = EdgeRise;
    end else if (prev_d > cfg_i.equ && sample_i <= cfg_i.equ) begin
      item_o.edge_kind = EdgeFall;
    end else begin
      item_o.edge_kind = EdgeNone;
    end
  end

  // The sample register resets to zero.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q  <= '0;
      win_q  <= '0;
      run_q  <= '0;
      held_q <= '0;
    end else if (acc) begin
      cur_q  <= sample_i;
      win_q  <= win_d;
      run_q  <= run_d;
      held_q <= held_d;
    end
  end
endmodule

>>> rtl/spd_queue.sv
// ----------------------------------------------------------------------------
// spd_queue
// Short FIFO of classified items between front and back.
// ----------------------------------------------------------------------------
module spd_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  spd_pkg::item_t item_i,
  output logic           full_o,
  output logic           valid_o,
  input  logic           pop_i,
  output spd_pkg::item_t item_o
);
  import spd_pkg::*;

  item_t     mem_q [QDepth];
  logic      wp_q, rp_q;
  logic [1:0] cnt_q;

  assign full_o  = cnt_q == 2'(QDepth);
  assign valid_o = cnt_q != 2'd0;
  assign item_o  = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wp_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wp_q <= ~wp_q;
      end
      if (pop_i) begin
        rp_q <= ~rp_q;
      end
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end
endmodule

>>> rtl/spd_back.sv
// ----------------------------------------------------------------------------
// spd_back
// Pattern sequencer: event matching, serial period sum, serial divider.
// ----------------------------------------------------------------------------
module spd_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  spd_pkg::cfg_t  cfg_i,
  input  logic           valid_i,
  input  spd_pkg::item_t item_i,
  output logic           pop_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output logic [1:0]     edge_kind_o,
  output logic [2:0]     pattern_status_o,
  output logic           pin_pulse_o,
  output logic [15:0]    period_samples_o,
  output logic [16:0]    frequency_hz_o,
  output logic           level_above_o,
  output logic           clipping_o,
  output logic [7:0]     slope_value_o
);
  import spd_pkg::*;

  localparam logic [2:0] SIdle = 3'd0;
  localparam logic [2:0] SCmp  = 3'd1;
  localparam logic [2:0] SSum  = 3'd2;
  localparam logic [2:0] SDiv  = 3'd3;
  localparam logic [2:0] SOut  = 3'd4;

  logic [2:0]  st_q;
  item_t       it_q;
  logic [15:0] clk_q;
  logic [CntW-1:0] idx_q;
  logic [7:0]  miss_q, steep_q;
  logic [15:0] per_q, sum_q;
  logic [IdxW-1:0] sc_q;
  logic [CntW-1:0] sn_q;
  logic [7:0]  slopes_q [EventSlots];
  logic [15:0] times_q  [EventSlots];
  logic [7:0]  s0_q;
  logic [15:0] t0_q, td_q;
  logic [16:0] rem_q, quo_q;
  logic [4:0]  dc_q;
  logic [2:0]  stat_q;
  logic        pulse_q;
  logic [7:0]  miss_inc;
  logic [17:0] trial;
  logic [15:0] clk1;
  logic [IdxW-1:0] widx;
  logic [15:0] tdiff;
  logic        is_match, is_found;

  assign pop_o = st_q == SIdle && valid_i;
  assign out_valid_o = st_q == SOut;
  assign edge_kind_o = it_q.edge_kind;
  assign pattern_status_o = stat_q;
  assign pin_pulse_o = pulse_q;
  assign period_samples_o = per_q;
  assign frequency_hz_o = quo_q;
  assign level_above_o = it_q.level_above;
  assign clipping_o = it_q.clipping;
  assign slope_value_o = it_q.slope;
  assign miss_inc = miss_q + 8'd1;
  assign clk1 = clk_q + 16'd1;
  assign widx = (idx_q >= CntW'(EventSlots)) ? '0 : idx_q[IdxW-1:0];
  assign trial = {rem_q, quo_q[16]} - {2'b0, per_q};
  assign tdiff = (t0_q >= clk_q) ? t0_q - clk_q : clk_q - t0_q;
  assign is_match = st_q == SCmp && it_q.edge_kind == EdgeRise &&
                    absdiff8(it_q.slope, steep_q) < cfg_i.slope_tol;
  assign is_found = is_match && widx != '0 && tdiff < cfg_i.timer_tol &&
                    absdiff8(s0_q, it_q.slope) < cfg_i.slope_tol;

  always_ff @(posedge clk_i) begin
    if (is_match) begin
      slopes_q[widx] <= it_q.slope;
      times_q[widx]  <= clk_q;
    end
    if (is_found) begin
      slopes_q[0] <= it_q.slope;
      times_q[0]  <= clk_q;
    end
    s0_q <= slopes_q[0];
    t0_q <= times_q[0];
    td_q <= times_q[sc_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= SIdle;
      clk_q <= '0;
      idx_q <= '0;
      miss_q <= '0;
      steep_q <= '0;
      per_q <= '0;
      sum_q <= '0;
      sc_q <= '0;
      sn_q <= '0;
      rem_q <= '0;
      quo_q <= '0;
      dc_q <= '0;
      stat_q <= StNone;
      pulse_q <= 1'b0;
      it_q <= '0;
    end else begin
      case (st_q)
        SIdle: begin
          if (valid_i) begin
            it_q <= item_i;
            clk_q <= clk1;
            st_q <= SCmp;
          end
        end
        SCmp: begin
          stat_q <= StNone;
          pulse_q <= 1'b0;
          st_q <= SDiv;
          if (it_q.edge_kind == EdgeRise) begin
            if (absdiff8(it_q.slope, steep_q) < cfg_i.slope_tol) begin
              if (widx == '0) begin
                if (idx_q >= CntW'(EventSlots)) begin
                  steep_q <= '0;
                end
                clk_q <= '0;
                miss_q <= '0;
                idx_q <= CntW'(1);
                stat_q <= StInit;
              end else if (((t0_q >= clk_q) ? t0_q - clk_q : clk_q - t0_q)
                           < cfg_i.timer_tol &&
                           absdiff8(s0_q, it_q.slope) < cfg_i.slope_tol) begin
                clk_q <= '0;
                miss_q <= '0;
                idx_q <= CntW'(1);
                stat_q <= StFound;
                pulse_q <= 1'b1;
                sum_q <= '0;
                sn_q <= CntW'(widx);
                sc_q <= IdxW'(1);
                st_q <= SSum;
              end else begin
                clk_q <= '0;
                stat_q <= StMiss;
                if (idx_q + CntW'(1) >= CntW'(EventSlots)) begin
                  idx_q <= '0;
                  miss_q <= '0;
                  steep_q <= '0;
                end else begin
                  idx_q <= idx_q + CntW'(1);
                end
              end
            end else if (it_q.slope > steep_q) begin
              steep_q <= it_q.slope;
              miss_q <= '0;
              clk_q <= '0;
              idx_q <= '0;
              pulse_q <= 1'b1;
              stat_q <= StSteep;
            end else begin
              stat_q <= StMiss;
              if (miss_inc >= 8'(EventSlots)) begin
                idx_q <= '0;
                clk_q <= '0;
                miss_q <= '0;
                steep_q <= '0;
              end else begin
                miss_q <= miss_inc;
              end
            end
          end
          rem_q <= '0;
          quo_q <= cfg_i.rate;
          dc_q <= 5'd17;
        end
        SSum: begin
          // Slot 0 is summed from the copy taken before its overwrite.
          sum_q <= sum_q + ((sc_q == IdxW'(1)) ? t0_q : td_q);
          if (CntW'(sc_q) >= sn_q) begin
            per_q <= sum_q + ((sc_q == IdxW'(1)) ? t0_q : td_q);
            sc_q <= '0;
            st_q <= SDiv;
          end else begin
            sc_q <= sc_q + IdxW'(1);
          end
        end
        SDiv: begin
          if (per_q == '0) begin
            quo_q <= '0;
            st_q <= SOut;
          end else begin
            if (!trial[17]) begin
              rem_q <= trial[16:0];
              quo_q <= {quo_q[15:0], 1'b1};
            end else begin
              rem_q <= {rem_q[15:0], quo_q[16]};
              quo_q <= {quo_q[15:0], 1'b0};
            end
            dc_q <= dc_q - 5'd1;
            if (dc_q == 5'd1) begin
              st_q <= SOut;
            end
          end
        end
        SOut: begin
          if (out_ready_i) begin
            st_q <= SIdle;
          end
        end
        default: st_q <= SIdle;
      endcase
    end
  end
endmodule

>>> rtl/slope_pattern_pitch_detector.sv
// ----------------------------------------------------------------------------
// slope_pattern_pitch_detector
// Zero crossing pitch detector that matches rising edges by slope and time.
// ----------------------------------------------------------------------------
// Each sample yields one result. The front end takes a sample whenever the
// queue is not full; the back end then runs the 17 step restoring divider
// for each sample, plus a serial period sum over the event slots when a
// period is found. A two entry queue decouples the two sides.
`include "slope_pattern_pitch_detector_defines.svh"
module slope_pattern_pitch_detector (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [16:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  sample_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  edge_kind_o,
  output logic [2:0]  pattern_status_o,
  output logic        pin_pulse_o,
  output logic [15:0] period_samples_o,
  output logic [16:0] frequency_hz_o,
  output logic        level_above_o,
  output logic        clipping_o,
  output logic [7:0]  slope_value_o
);
  import spd_pkg::*;

  cfg_t  cfg_q;
  item_t f_item, q_item;
  logic  push, full, q_valid, pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{equ: 8'd128, slope_tol: 8'd3, timer_tol: 16'd10, amp_thr: 8'd30,
                 window: 16'd1000, rate: 17'd38462, adc_min: 8'd0, adc_max: 8'd255};
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CfgEqu:  cfg_q.equ <= cfg_data_i[7:0];
        CfgSlt:  cfg_q.slope_tol <= cfg_data_i[7:0];
        CfgTmt:  cfg_q.timer_tol <= cfg_data_i[15:0];
        CfgAmp:  cfg_q.amp_thr <= cfg_data_i[7:0];
        CfgWin:  cfg_q.window <= cfg_data_i[15:0];
        CfgRate: cfg_q.rate <= cfg_data_i;
        CfgMin:  cfg_q.adc_min <= cfg_data_i[7:0];
        CfgMax:  cfg_q.adc_max <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  spd_front u_front (
    .clk_i, .rst_ni, .cfg_i(cfg_q), .valid_i(in_valid_i), .ready_o(in_ready_o),
    .sample_i, .push_o(push), .item_o(f_item), .full_i(full)
  );

  spd_queue u_queue (
    .clk_i, .rst_ni, .push_i(push), .item_i(f_item), .full_o(full),
    .valid_o(q_valid), .pop_i(pop), .item_o(q_item)
  );

  spd_back u_back (
    .clk_i, .rst_ni, .cfg_i(cfg_q), .valid_i(q_valid), .item_i(q_item), .pop_o(pop),
    .out_valid_o, .out_ready_i, .edge_kind_o, .pattern_status_o, .pin_pulse_o,
    .period_samples_o, .frequency_hz_o, .level_above_o, .clipping_o, .slope_value_o
  );

  `SPD_ASSERT(a_pulse_status, clk_i, rst_ni,
    (out_valid_o && pin_pulse_o) |-> (pattern_status_o == StSteep ||
      pattern_status_o == StFound))
  `SPD_ASSERT(a_status_edge, clk_i, rst_ni,
    (out_valid_o && pattern_status_o != StNone) |-> (edge_kind_o == EdgeRise))
  `SPD_ASSERT(a_out_hold, clk_i, rst_ni,
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(frequency_hz_o)))
endmodule
